// ----- src/mkm_pkg.sv -----
// ----------------------------------------------------------------------------
// Mouse-key motion controller package
// Shared codes, register defaults, payload types and the speed ramp function.
// ----------------------------------------------------------------------------
`default_nettype none

package mkm_pkg;

    // Request action codes
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_PRESS   = 3'd1;
    localparam logic [2:0] ACT_RELEASE = 3'd2;
    localparam logic [2:0] ACT_CLEAR   = 3'd3;
    localparam logic [2:0] ACT_SEND    = 3'd4;

    // Mouse keys live in the top page of the keycode space
    localparam logic [3:0] KEY_PAGE        = 4'hF;
    localparam logic [3:0] KEY_UP          = 4'h0;
    localparam logic [3:0] KEY_DOWN        = 4'h1;
    localparam logic [3:0] KEY_LEFT        = 4'h2;
    localparam logic [3:0] KEY_RIGHT       = 4'h3;
    localparam logic [3:0] KEY_BTN1        = 4'h4;
    localparam logic [3:0] KEY_BTN2        = 4'h5;
    localparam logic [3:0] KEY_BTN3        = 4'h6;
    localparam logic [3:0] KEY_BTN4        = 4'h7;
    localparam logic [3:0] KEY_BTN5        = 4'h8;
    localparam logic [3:0] KEY_WHEEL_UP    = 4'h9;
    localparam logic [3:0] KEY_WHEEL_DOWN  = 4'hA;
    localparam logic [3:0] KEY_WHEEL_LEFT  = 4'hB;
    localparam logic [3:0] KEY_WHEEL_RIGHT = 4'hC;
    localparam logic [3:0] KEY_ACCEL0      = 4'hD;
    localparam logic [3:0] KEY_ACCEL1      = 4'hE;
    localparam logic [3:0] KEY_ACCEL2      = 4'hF;

    // Configuration register indexes
    localparam logic [1:0] CFG_TOP_SPEED    = 2'd0;
    localparam logic [1:0] CFG_RAMP_PERIOD  = 2'd1;
    localparam logic [1:0] CFG_RAMP_RESTART = 2'd2;

    // Register defaults
    localparam logic [6:0] TOP_SPEED_RST    = 7'd20;
    localparam logic [7:0] RAMP_PERIOD_RST  = 8'd12;
    localparam logic [7:0] RAMP_RESTART_RST = 8'd0;

    // Report timing
    localparam logic [15:0] SLOW_WAIT_MS   = 16'd50;
    localparam logic [15:0] FAST_WAIT_MS   = 16'd5;
    localparam logic [15:0] MS_SAT         = 16'hFFFF;
    localparam logic [3:0]  WHEEL_DIV_MASK = 4'hF;

    localparam logic signed [7:0] SPEED_POS1 = 8'sd1;
    localparam logic signed [7:0] SPEED_NEG1 = -8'sd1;
    localparam logic [6:0]        MAG_SAT    = 7'd127;

    typedef struct packed {
        logic [6:0] top_speed;
        logic [7:0] ramp_period;
        logic [7:0] ramp_restart;
    } cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] key_code;
    } cmd_t;

    typedef struct packed {
        logic [4:0]        buttons;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
        logic signed [7:0] wheel_vertical;
        logic signed [7:0] wheel_horizontal;
    } report_t;

    // One ramp step of a signed speed: grow by one up to top, or jump to a
    // fixed magnitude of top/4 times the accel bits; sign kept, zero stays zero.
    function automatic logic signed [7:0] step_speed(
        input logic signed [7:0] s,
        input logic [6:0]        top,
        input logic [2:0]        accel
    );
        logic [7:0]        prod;
        logic [6:0]        sat;
        logic signed [8:0] up;
        logic signed [8:0] dn;
        logic signed [8:0] lim;
        logic signed [8:0] nlim;
        logic signed [7:0] res;
        prod = {3'b000, top[6:2]} * {5'b00000, accel};
        sat  = (prod > {1'b0, MAG_SAT}) ? MAG_SAT : prod[6:0];
        up   = {s[7], s} + 9'sd1;
        dn   = {s[7], s} - 9'sd1;
        lim  = $signed({2'b00, top});
        nlim = 9'sd0 - lim;
        if (s == 8'sd0)
            res = 8'sd0;
        else if (accel != 3'd0)
            res = s[7] ? $signed(8'd0 - {1'b0, sat}) : $signed({1'b0, sat});
        else if (!s[7])
            res = (up > lim) ? lim[7:0] : up[7:0];
        else
            res = (dn < nlim) ? nlim[7:0] : dn[7:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/mkm_stream_if.sv -----
// ----------------------------------------------------------------------------
// Mouse-key stream channel
// Valid/ready channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/mkm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Mouse-key configuration registers
// Holds max speed, ramp period and ramp restart value; write only.
// ----------------------------------------------------------------------------
`default_nettype none

module mkm_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    output mkm_pkg::cfg_t     cfg
);

    mkm_pkg::cfg_t cfg_reg;
    mkm_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes drop the data
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mkm_pkg::CFG_TOP_SPEED:    cfg_next.top_speed    = cfg_data[6:0];
                mkm_pkg::CFG_RAMP_PERIOD:  cfg_next.ramp_period  = cfg_data;
                mkm_pkg::CFG_RAMP_RESTART: cfg_next.ramp_restart = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_speed    <= mkm_pkg::TOP_SPEED_RST;
            cfg_reg.ramp_period  <= mkm_pkg::RAMP_PERIOD_RST;
            cfg_reg.ramp_restart <= mkm_pkg::RAMP_RESTART_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/mkm_engine.sv -----
// ----------------------------------------------------------------------------
// Mouse-key motion engine
// Holds buttons, speeds and timers; applies one request per cycle while fire
// is high and forms the report that the request causes.
// ----------------------------------------------------------------------------
`default_nettype none

module mkm_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire mkm_pkg::cmd_t   cmd,
    input  wire mkm_pkg::cfg_t   cfg,
    output logic                 rpt_valid,
    output mkm_pkg::report_t     rpt
);

    logic [4:0]        buttons_reg,  buttons_next;
    logic signed [7:0] speed_x_reg,  speed_x_next;
    logic signed [7:0] speed_y_reg,  speed_y_next;
    logic signed [7:0] wheel_v_reg,  wheel_v_next;
    logic signed [7:0] wheel_h_reg,  wheel_h_next;
    logic [2:0]        accel_reg,    accel_next;
    logic [7:0]        wheel_div_reg, wheel_div_next;
    logic [7:0]        ramp_reg,     ramp_next;
    logic [15:0]       ms_reg,       ms_next;
    logic              fast_reg,     fast_next;

    logic [15:0] ms_inc;
    logic [15:0] wait_ms;
    logic [7:0]  wheel_div_inc;
    logic [7:0]  ramp_inc;
    logic        moving;
    logic        mouse_key;
    logic [3:0]  key;
    logic [4:0]  btn_bit;
    logic [2:0]  accel_bit;

    // Work out the next state and any report for the request
    always_comb
    begin
        buttons_next   = buttons_reg;
        speed_x_next   = speed_x_reg;
        speed_y_next   = speed_y_reg;
        wheel_v_next   = wheel_v_reg;
        wheel_h_next   = wheel_h_reg;
        accel_next     = accel_reg;
        wheel_div_next = wheel_div_reg;
        ramp_next      = ramp_reg;
        ms_next        = ms_reg;
        fast_next      = fast_reg;

        ms_inc        = (ms_reg == mkm_pkg::MS_SAT) ? ms_reg : ms_reg + 16'd1;
        wait_ms       = fast_reg ? mkm_pkg::FAST_WAIT_MS : mkm_pkg::SLOW_WAIT_MS;
        wheel_div_inc = wheel_div_reg + 8'd1;
        ramp_inc      = ramp_reg + 8'd1;
        moving        = (speed_x_reg != 8'sd0) || (speed_y_reg != 8'sd0)
                     || (wheel_v_reg != 8'sd0) || (wheel_h_reg != 8'sd0);
        mouse_key     = (cmd.key_code[7:4] == mkm_pkg::KEY_PAGE);
        key           = cmd.key_code[3:0];
        btn_bit       = 5'(5'b00001 << (key - mkm_pkg::KEY_BTN1));
        accel_bit     = 3'(3'b001 << (key - mkm_pkg::KEY_ACCEL0));

        rpt_valid             = 1'b0;
        rpt.buttons           = buttons_reg;
        rpt.move_x            = speed_x_reg;
        rpt.move_y            = speed_y_reg;
        rpt.wheel_vertical    = wheel_v_reg;
        rpt.wheel_horizontal  = wheel_h_reg;

        unique case (cmd.action)
            mkm_pkg::ACT_TICK:
            begin
                ms_next = ms_inc;
                if (ms_inc >= wait_ms)
                begin
                    if (!moving)
                    begin
                        // nothing moving: fall back to the slow wait
                        fast_next = 1'b0;
                    end
                    else
                    begin
                        fast_next      = 1'b1;
                        wheel_div_next = wheel_div_inc;
                        rpt_valid      = 1'b1;
                        ms_next        = '0;
                        // drop the wheel on divided reports
                        if ((wheel_div_inc[3:0] & mkm_pkg::WHEEL_DIV_MASK) != 4'd0)
                        begin
                            rpt.wheel_vertical   = 8'sd0;
                            rpt.wheel_horizontal = 8'sd0;
                        end
                        // advance the ramp
                        if (ramp_inc > cfg.ramp_period)
                        begin
                            ramp_next    = cfg.ramp_restart;
                            speed_x_next = mkm_pkg::step_speed(speed_x_reg,
                                               cfg.top_speed, accel_reg);
                            speed_y_next = mkm_pkg::step_speed(speed_y_reg,
                                               cfg.top_speed, accel_reg);
                            wheel_v_next = mkm_pkg::step_speed(wheel_v_reg,
                                               cfg.top_speed, accel_reg);
                            wheel_h_next = mkm_pkg::step_speed(wheel_h_reg,
                                               cfg.top_speed, accel_reg);
                        end
                        else
                        begin
                            ramp_next = ramp_inc;
                        end
                    end
                end
            end
            mkm_pkg::ACT_PRESS:
            begin
                if (mouse_key)
                begin
                    unique case (key)
                        mkm_pkg::KEY_UP:          speed_y_next = mkm_pkg::SPEED_NEG1;
                        mkm_pkg::KEY_DOWN:        speed_y_next = mkm_pkg::SPEED_POS1;
                        mkm_pkg::KEY_LEFT:        speed_x_next = mkm_pkg::SPEED_NEG1;
                        mkm_pkg::KEY_RIGHT:       speed_x_next = mkm_pkg::SPEED_POS1;
                        mkm_pkg::KEY_BTN1, mkm_pkg::KEY_BTN2, mkm_pkg::KEY_BTN3,
                        mkm_pkg::KEY_BTN4, mkm_pkg::KEY_BTN5:
                            buttons_next = buttons_reg | btn_bit;
                        mkm_pkg::KEY_WHEEL_UP:
                        begin
                            wheel_v_next   = mkm_pkg::SPEED_POS1;
                            wheel_div_next = '0;
                        end
                        mkm_pkg::KEY_WHEEL_DOWN:
                        begin
                            wheel_v_next   = mkm_pkg::SPEED_NEG1;
                            wheel_div_next = '0;
                        end
                        mkm_pkg::KEY_WHEEL_LEFT:
                        begin
                            wheel_h_next   = mkm_pkg::SPEED_NEG1;
                            wheel_div_next = '0;
                        end
                        mkm_pkg::KEY_WHEEL_RIGHT:
                        begin
                            wheel_h_next   = mkm_pkg::SPEED_POS1;
                            wheel_div_next = '0;
                        end
                        mkm_pkg::KEY_ACCEL0, mkm_pkg::KEY_ACCEL1, mkm_pkg::KEY_ACCEL2:
                            accel_next = accel_reg | accel_bit;
                    endcase
                end
            end
            mkm_pkg::ACT_RELEASE:
            begin
                // a direction clears only if its sign matches the key
                if (mouse_key)
                begin
                    unique case (key)
                        mkm_pkg::KEY_UP:
                            if (speed_y_reg < 8'sd0) speed_y_next = 8'sd0;
                        mkm_pkg::KEY_DOWN:
                            if (speed_y_reg > 8'sd0) speed_y_next = 8'sd0;
                        mkm_pkg::KEY_LEFT:
                            if (speed_x_reg < 8'sd0) speed_x_next = 8'sd0;
                        mkm_pkg::KEY_RIGHT:
                            if (speed_x_reg > 8'sd0) speed_x_next = 8'sd0;
                        mkm_pkg::KEY_BTN1, mkm_pkg::KEY_BTN2, mkm_pkg::KEY_BTN3,
                        mkm_pkg::KEY_BTN4, mkm_pkg::KEY_BTN5:
                            buttons_next = buttons_reg & ~btn_bit;
                        mkm_pkg::KEY_WHEEL_UP:
                            if (wheel_v_reg > 8'sd0) wheel_v_next = 8'sd0;
                        mkm_pkg::KEY_WHEEL_DOWN:
                            if (wheel_v_reg < 8'sd0) wheel_v_next = 8'sd0;
                        mkm_pkg::KEY_WHEEL_LEFT:
                            if (wheel_h_reg < 8'sd0) wheel_h_next = 8'sd0;
                        mkm_pkg::KEY_WHEEL_RIGHT:
                            if (wheel_h_reg > 8'sd0) wheel_h_next = 8'sd0;
                        mkm_pkg::KEY_ACCEL0, mkm_pkg::KEY_ACCEL1, mkm_pkg::KEY_ACCEL2:
                            accel_next = accel_reg & ~accel_bit;
                    endcase
                end
            end
            mkm_pkg::ACT_CLEAR:
            begin
                // keep the timers
                buttons_next = '0;
                accel_next   = '0;
                speed_x_next = 8'sd0;
                speed_y_next = 8'sd0;
                wheel_v_next = 8'sd0;
                wheel_h_next = 8'sd0;
            end
            mkm_pkg::ACT_SEND:
            begin
                rpt_valid = 1'b1;
                ms_next   = '0;
            end
            default:
            begin
                rpt_valid = 1'b0;
            end
        endcase
    end

    // Hold state; update only when a request is applied
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buttons_reg   <= '0;
            speed_x_reg   <= '0;
            speed_y_reg   <= '0;
            wheel_v_reg   <= '0;
            wheel_h_reg   <= '0;
            accel_reg     <= '0;
            wheel_div_reg <= '0;
            ramp_reg      <= '0;
            ms_reg        <= '0;
            fast_reg      <= 1'b0;
        end
        else if (fire)
        begin
            buttons_reg   <= buttons_next;
            speed_x_reg   <= speed_x_next;
            speed_y_reg   <= speed_y_next;
            wheel_v_reg   <= wheel_v_next;
            wheel_h_reg   <= wheel_h_next;
            accel_reg     <= accel_next;
            wheel_div_reg <= wheel_div_next;
            ramp_reg      <= ramp_next;
            ms_reg        <= ms_next;
            fast_reg      <= fast_next;
        end
    end

    // A clear leaves no motion and no buttons behind
    a_clear_stops: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cmd.action == mkm_pkg::ACT_CLEAR) |=>
            (buttons_reg == 5'd0) && (accel_reg == 3'd0) && (speed_x_reg == 8'sd0)
            && (speed_y_reg == 8'sd0) && (wheel_v_reg == 8'sd0) && (wheel_h_reg == 8'sd0))
        else $error("clear left state behind");

    // Every report restarts the millisecond count
    a_report_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && rpt_valid |=> (ms_reg == 16'd0))
        else $error("report did not restart the ms count");

    // Fast repeat is entered only by a tick report
    a_fast_on_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fast_reg) |-> $past(fire && rpt_valid && (cmd.action == mkm_pkg::ACT_TICK)))
        else $error("fast repeat set without a tick report");

    // Speeds never reach the unrepresentable magnitude
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (speed_x_reg != -8'sd128) && (speed_y_reg != -8'sd128)
        && (wheel_v_reg != -8'sd128) && (wheel_h_reg != -8'sd128))
        else $error("speed out of range");

endmodule

`default_nettype wire

// ----- src/mouse_key_motion_controller.sv -----
// ----------------------------------------------------------------------------
// Mouse-key motion controller
// Turns mouse key events and 1 ms ticks into pointer and wheel reports.
// ----------------------------------------------------------------------------
// A request goes through the input register, then the report register;
//   requests with no report leave none. Throughput: one request per cycle
//   unless a held report stalls, set by the single state update stage.
// Reset: rst_n clears all motion state and timers and loads the register
//   defaults (max speed 20, ramp period 12, ramp restart 0).
`default_nettype none

module mouse_key_motion_controller (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [1:0]                            cfg_index,
    input  wire logic [7:0]                            cfg_data,
    mkm_stream_if.sink                                 cmd,
    mkm_stream_if.source                               rpt
);

    mkm_pkg::cfg_t    cfg;
    mkm_pkg::cmd_t    cmd_reg;
    logic             cmd_valid_reg;
    logic             cmd_valid_next;
    logic             adv;
    logic             eng_valid;
    mkm_pkg::report_t eng_rpt;
    mkm_pkg::report_t rpt_reg;
    logic             rpt_valid_reg;
    logic             rpt_valid_next;

    mkm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Apply the held request once the report slot can take its result
    assign adv       = cmd_valid_reg && (!rpt_valid_reg || rpt.ready);
    assign cmd.ready = !cmd_valid_reg || adv;

    mkm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (adv),
        .cmd       (cmd_reg),
        .cfg       (cfg),
        .rpt_valid (eng_valid),
        .rpt       (eng_rpt)
    );

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd.valid && cmd.ready)
            cmd_valid_next = 1'b1;
        else if (adv)
            cmd_valid_next = 1'b0;

        rpt_valid_next = rpt_valid_reg;
        if (adv)
            rpt_valid_next = eng_valid;
        else if (rpt.ready)
            rpt_valid_next = 1'b0;
    end

    // Input register: take a new request whenever the slot frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= cmd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            cmd_reg <= cmd.data;
    end

    // Report register: hold a result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rpt_valid_reg <= 1'b0;
        else
            rpt_valid_reg <= rpt_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && eng_valid)
            rpt_reg <= eng_rpt;
    end

    assign rpt.valid = rpt_valid_reg;
    assign rpt.data  = rpt_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Mouse-key motion controller regression bench
// Drives key, tick, clear and send-now requests into the controller and
// predicts every pointer/wheel report in step with the accepted requests.
// Each report is compared field by field. Covered: directed corner requests,
// a long idle stretch, a long output stall, and random key sessions
// across several register settings.
// ----------------------------------------------------------------------------
module tb_top;

    // Action codes that the controller ignores
    localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;
    // Keycodes outside the mouse-key page
    localparam logic [7:0] KEY_ZERO       = 8'h00;
    localparam logic [7:0] KEY_BELOW_PAGE = 8'hEF;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 64;
    localparam int PRINT_CAP     = 25;
    localparam int IDLE_TICKS    = 120;
    localparam int SESSION_QUOTA = 250;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    mkm_stream_if #(.T(mkm_pkg::cmd_t))    cmd_if ();
    mkm_stream_if #(.T(mkm_pkg::report_t)) rpt_if ();

    mouse_key_motion_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .rpt       (rpt_if)
    );

    // Predicted controller state
    mkm_pkg::cfg_t     cur_cfg   = '{mkm_pkg::TOP_SPEED_RST, mkm_pkg::RAMP_PERIOD_RST,
                                     mkm_pkg::RAMP_RESTART_RST};
    logic [4:0]        btn_held  = '0;
    logic [2:0]        accel_held = '0;
    logic signed [7:0] sp_x      = '0;
    logic signed [7:0] sp_y      = '0;
    logic signed [7:0] sp_wv     = '0;
    logic signed [7:0] sp_wh     = '0;
    logic [7:0]        wheel_div = '0;
    logic [7:0]        ramp_cnt  = '0;
    logic [15:0]       ms_idle   = '0;
    bit                fast_mode = 1'b0;

    mkm_pkg::report_t pending_reports[$];
    mkm_pkg::report_t got_rpt;
    mkm_pkg::report_t want_rpt;

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  reports_seen   = 0;
    int  events_counted = 0;
    int  reg_writes     = 0;
    int  rx_hold        = 0;
    int  stall_left     = 0;
    bit  tx_idle        = 1'b1;
    bit  rx_idle        = 1'b1;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("mouse_key_motion_controller regression: fail");
            $finish;
        end
    end

    function automatic logic [7:0] page_key(input logic [3:0] k);
        return {mkm_pkg::KEY_PAGE, k};
    endfunction

    function automatic logic [7:0] pick_mouse_key();
        return {mkm_pkg::KEY_PAGE, 4'($urandom_range(0, 15))};
    endfunction

    // One ramp step: grow magnitude by one up to max speed, or jump to the
    // fixed accel magnitude; sign kept, zero stays zero
    function automatic logic signed [7:0] ramp_speed(input logic signed [7:0] s);
        int top;
        int v;
        int mag;
        top = int'(cur_cfg.top_speed);
        v   = int'(s);
        if (v == 0)
            return 8'sd0;
        if (accel_held != 3'd0)
        begin
            mag = (top >> 2) * int'(accel_held);
            if (mag > 127)
                mag = 127;
            return (v > 0) ? 8'(mag) : 8'(-mag);
        end
        if (v > 0)
            return (v + 1 > top) ? 8'(top) : 8'(v + 1);
        return (v - 1 < -top) ? 8'(-top) : 8'(v - 1);
    endfunction

    task automatic queue_report(input bit wheel_on);
        mkm_pkg::report_t r;
        r.buttons          = btn_held;
        r.move_x           = sp_x;
        r.move_y           = sp_y;
        r.wheel_vertical   = wheel_on ? sp_wv : 8'sd0;
        r.wheel_horizontal = wheel_on ? sp_wh : 8'sd0;
        pending_reports.push_back(r);
        ms_idle = '0;
    endtask

    // Advance the predicted state by one accepted request
    task automatic apply_mouse_event(input mkm_pkg::cmd_t c);
        logic [3:0]  lo;
        bit          on_page;
        logic [15:0] wait_ms;
        lo      = c.key_code[3:0];
        on_page = (c.key_code[7:4] == mkm_pkg::KEY_PAGE);
        case (c.action)
            mkm_pkg::ACT_TICK:
            begin
                if (ms_idle != mkm_pkg::MS_SAT)
                    ms_idle++;
                wait_ms = fast_mode ? mkm_pkg::FAST_WAIT_MS : mkm_pkg::SLOW_WAIT_MS;
                if (ms_idle >= wait_ms)
                begin
                    if (sp_x == 0 && sp_y == 0 && sp_wv == 0 && sp_wh == 0)
                        fast_mode = 1'b0;
                    else
                    begin
                        fast_mode = 1'b1;
                        wheel_div++;
                        queue_report((wheel_div[3:0] & mkm_pkg::WHEEL_DIV_MASK) == 4'd0);
                        ramp_cnt++;
                        if (ramp_cnt > cur_cfg.ramp_period)
                        begin
                            ramp_cnt = cur_cfg.ramp_restart;
                            sp_x  = ramp_speed(sp_x);
                            sp_y  = ramp_speed(sp_y);
                            sp_wv = ramp_speed(sp_wv);
                            sp_wh = ramp_speed(sp_wh);
                        end
                    end
                end
            end
            mkm_pkg::ACT_PRESS:
            begin
                if (on_page)
                begin
                    case (lo)
                        mkm_pkg::KEY_UP:          sp_y = mkm_pkg::SPEED_NEG1;
                        mkm_pkg::KEY_DOWN:        sp_y = mkm_pkg::SPEED_POS1;
                        mkm_pkg::KEY_LEFT:        sp_x = mkm_pkg::SPEED_NEG1;
                        mkm_pkg::KEY_RIGHT:       sp_x = mkm_pkg::SPEED_POS1;
                        mkm_pkg::KEY_BTN1, mkm_pkg::KEY_BTN2, mkm_pkg::KEY_BTN3,
                        mkm_pkg::KEY_BTN4, mkm_pkg::KEY_BTN5:
                            btn_held |= 5'b1 << (lo - mkm_pkg::KEY_BTN1);
                        mkm_pkg::KEY_WHEEL_UP:    sp_wv = mkm_pkg::SPEED_POS1;
                        mkm_pkg::KEY_WHEEL_DOWN:  sp_wv = mkm_pkg::SPEED_NEG1;
                        mkm_pkg::KEY_WHEEL_LEFT:  sp_wh = mkm_pkg::SPEED_NEG1;
                        mkm_pkg::KEY_WHEEL_RIGHT: sp_wh = mkm_pkg::SPEED_POS1;
                        default:
                            accel_held |= 3'b1 << (lo - mkm_pkg::KEY_ACCEL0);
                    endcase
                    if (lo >= mkm_pkg::KEY_WHEEL_UP && lo <= mkm_pkg::KEY_WHEEL_RIGHT)
                        wheel_div = '0;
                end
            end
            mkm_pkg::ACT_RELEASE:
            begin
                if (on_page)
                begin
                    // Direction releases only cancel motion of their own sign
                    case (lo)
                        mkm_pkg::KEY_UP:          if (sp_y < 0) sp_y = '0;
                        mkm_pkg::KEY_DOWN:        if (sp_y > 0) sp_y = '0;
                        mkm_pkg::KEY_LEFT:        if (sp_x < 0) sp_x = '0;
                        mkm_pkg::KEY_RIGHT:       if (sp_x > 0) sp_x = '0;
                        mkm_pkg::KEY_BTN1, mkm_pkg::KEY_BTN2, mkm_pkg::KEY_BTN3,
                        mkm_pkg::KEY_BTN4, mkm_pkg::KEY_BTN5:
                            btn_held &= ~(5'b1 << (lo - mkm_pkg::KEY_BTN1));
                        mkm_pkg::KEY_WHEEL_UP:    if (sp_wv > 0) sp_wv = '0;
                        mkm_pkg::KEY_WHEEL_DOWN:  if (sp_wv < 0) sp_wv = '0;
                        mkm_pkg::KEY_WHEEL_LEFT:  if (sp_wh < 0) sp_wh = '0;
                        mkm_pkg::KEY_WHEEL_RIGHT: if (sp_wh > 0) sp_wh = '0;
                        default:
                            accel_held &= ~(3'b1 << (lo - mkm_pkg::KEY_ACCEL0));
                    endcase
                end
            end
            mkm_pkg::ACT_CLEAR:
            begin
                btn_held   = '0;
                accel_held = '0;
                sp_x       = '0;
                sp_y       = '0;
                sp_wv      = '0;
                sp_wh      = '0;
            end
            mkm_pkg::ACT_SEND:
                queue_report(1'b1);
            default:
            begin
            end
        endcase
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            flag_mismatch($sformatf("report %0d %s got %0d expected %0d",
                                    reports_seen, name, $signed(got), $signed(want)));
    endtask

    // Compare each accepted report with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rpt_if.valid && rpt_if.ready)
        begin
            got_rpt = rpt_if.data;
            if (pending_reports.size() == 0)
                flag_mismatch("report with none outstanding");
            else
            begin
                want_rpt = pending_reports.pop_front();
                check_field("buttons", {3'b000, got_rpt.buttons},
                            {3'b000, want_rpt.buttons});
                check_field("move_x", got_rpt.move_x, want_rpt.move_x);
                check_field("move_y", got_rpt.move_y, want_rpt.move_y);
                check_field("wheel_vertical", got_rpt.wheel_vertical,
                            want_rpt.wheel_vertical);
                check_field("wheel_horizontal", got_rpt.wheel_horizontal,
                            want_rpt.wheel_horizontal);
            end
            reports_seen++;
        end
    end

    // Report sink: hold off on request, else, while rx_idle is set, stall in short random bursts
    initial
    begin
        rpt_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rpt_if.ready = 1'b0;
                stall_left--;
            end
            else if (rx_hold > 0)
            begin
                rpt_if.ready = 1'b0;
                stall_left   = rx_hold - 1;
                rx_hold      = 0;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                rpt_if.ready = 1'b0;
                stall_left   = $urandom_range(0, 5);
            end
            else
                rpt_if.ready = 1'b1;
        end
    end

    // Offer one request and wait for it to be taken
    task automatic send_event(input logic [2:0] action, input logic [7:0] key);
        mkm_pkg::cmd_t c;
        int            gap;
        c.action   = action;
        c.key_code = key;
        @(negedge clk);
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            cmd_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid = 1'b1;
        cmd_if.data  = c;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        apply_mouse_event(c);
        if (action <= mkm_pkg::ACT_SEND &&
            !((action == mkm_pkg::ACT_PRESS || action == mkm_pkg::ACT_RELEASE) &&
              key[7:4] != mkm_pkg::KEY_PAGE))
            events_counted++;
    endtask

    // Drop the request line and wait for every outstanding report
    task automatic settle_block();
        @(negedge clk);
        cmd_if.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        settle_block();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            mkm_pkg::CFG_TOP_SPEED:    cur_cfg.top_speed    = val[6:0];
            mkm_pkg::CFG_RAMP_PERIOD:  cur_cfg.ramp_period  = val;
            mkm_pkg::CFG_RAMP_RESTART: cur_cfg.ramp_restart = val;
            default:
            begin
            end
        endcase
        reg_writes++;
    endtask

    task automatic test_directed();
        send_event(mkm_pkg::ACT_SEND, KEY_ZERO);
        send_event(mkm_pkg::ACT_PRESS, KEY_ZERO);
        send_event(mkm_pkg::ACT_PRESS, KEY_BELOW_PAGE);
        send_event(ACT_UNUSED_LO, page_key(mkm_pkg::KEY_ACCEL2));
        send_event(ACT_UNUSED_HI, page_key(mkm_pkg::KEY_UP));
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_UP));
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_RIGHT));
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_BTN1));
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_BTN5));
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_WHEEL_UP));
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_WHEEL_LEFT));
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_ACCEL2));
        send_event(mkm_pkg::ACT_TICK, 8'hFF);
        send_event(mkm_pkg::ACT_SEND, 8'hFF);
        // Opposite-sign release leaves the axis moving
        send_event(mkm_pkg::ACT_RELEASE, page_key(mkm_pkg::KEY_DOWN));
        send_event(mkm_pkg::ACT_RELEASE, page_key(mkm_pkg::KEY_UP));
        send_event(mkm_pkg::ACT_RELEASE, page_key(mkm_pkg::KEY_BTN1));
        send_event(mkm_pkg::ACT_RELEASE, page_key(mkm_pkg::KEY_ACCEL2));
        send_event(mkm_pkg::ACT_RELEASE, KEY_BELOW_PAGE);
        send_event(mkm_pkg::ACT_SEND, KEY_ZERO);
        send_event(mkm_pkg::ACT_CLEAR, KEY_ZERO);
        send_event(mkm_pkg::ACT_TICK, KEY_ZERO);
        send_event(mkm_pkg::ACT_SEND, KEY_ZERO);
        settle_block();
    endtask

    // Let the idle counter run well past the slow wait, then move: report on
    // the first tick
    task automatic test_long_idle();
        tx_idle = 1'b0;
        send_event(mkm_pkg::ACT_CLEAR, KEY_ZERO);
        repeat (IDLE_TICKS) send_event(mkm_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_RIGHT));
        send_event(mkm_pkg::ACT_TICK, KEY_ZERO);
        send_event(mkm_pkg::ACT_CLEAR, KEY_ZERO);
        settle_block();
        tx_idle = 1'b1;
    endtask

    // Stall the report side for a long stretch while send-now requests pile up
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_hold = HOLD_CYCLES;
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_LEFT));
        send_event(mkm_pkg::ACT_PRESS, page_key(mkm_pkg::KEY_BTN3));
        repeat (24) send_event(mkm_pkg::ACT_SEND, 8'($urandom_range(0, 255)));
        send_event(mkm_pkg::ACT_CLEAR, KEY_ZERO);
        settle_block();
        tx_idle = 1'b1;
    endtask

    // Random key sessions: presses, a run of ticks with stray requests mixed
    // in, some releases, now and then a clear; some bursts of pure noise
    task automatic run_key_sessions(input int quota);
        int start;
        int n_ticks;
        start = events_counted;
        while (events_counted - start < quota)
        begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4))
                    send_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_event(mkm_pkg::ACT_PRESS, pick_mouse_key());
                n_ticks = $urandom_range(10, 90);
                repeat (n_ticks)
                begin
                    if ($urandom_range(0, 11) == 0)
                    begin
                        case ($urandom_range(0, 2))
                            0:       send_event(mkm_pkg::ACT_PRESS, pick_mouse_key());
                            1:       send_event(mkm_pkg::ACT_RELEASE, pick_mouse_key());
                            default: send_event(mkm_pkg::ACT_SEND,
                                                8'($urandom_range(0, 255)));
                        endcase
                    end
                    else
                        send_event(mkm_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
                end
                repeat ($urandom_range(0, 3))
                    send_event(mkm_pkg::ACT_RELEASE, pick_mouse_key());
                if ($urandom_range(0, 5) == 0)
                    send_event(mkm_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Sweep register settings; motion state carries over so a lowered top
    // speed clamps speeds already above it
    task automatic test_config_sweep();
        int max_tab[6]     = '{127, 1, 0, 127, 40, 0};
        int period_tab[6]  = '{0, 254, 3, 5, 12, 0};
        int restart_tab[6] = '{0, 254, 2, 200, 254, 0};
        int p;
        for (p = 0; p < 6; p++)
        begin
            if (p == 5)
            begin
                max_tab[p]     = $urandom_range(0, 127);
                period_tab[p]  = $urandom_range(0, 254);
                restart_tab[p] = $urandom_range(0, 254);
                // Final stretch runs flat out on both sides
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            write_reg(mkm_pkg::CFG_TOP_SPEED, 8'(max_tab[p]));
            write_reg(mkm_pkg::CFG_RAMP_PERIOD, 8'(period_tab[p]));
            write_reg(mkm_pkg::CFG_RAMP_RESTART, 8'(restart_tab[p]));
            run_key_sessions(SESSION_QUOTA);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = mkm_pkg::CFG_TOP_SPEED;
        cfg_data     = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_long_idle();
        test_backpressure();
        test_config_sweep();

        settle_block();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("covered %0d requests and %0d checked reports", events_counted, reports_seen);
        $display("register writes: %0d over six settings, %0d mismatches",
                 reg_writes, mismatch_count);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("mouse_key_motion_controller regression: pass");
        else
            $display("mouse_key_motion_controller regression: fail");
        $finish;
    end

endmodule
